// ===== hw/rtl/ctlex_pkg.sv =====
package ctlex_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } ctlex_in_t;

  typedef struct packed {
    logic [6:0]  token_kind;
    logic [31:0] value;
    logic [2:0]  error_code;
    logic        last;
  } ctlex_out_t;

  // results produced by one transfer, oldest in res0
  typedef struct packed {
    logic [1:0] cnt;
    ctlex_out_t res0;
    ctlex_out_t res1;
  } ctlex_emit_t;

  typedef enum logic [11:0] {
    M_IDLE   = 12'h001,
    M_OP     = 12'h002,
    M_LINE   = 12'h004,
    M_BLOCK  = 12'h008,
    M_IDENT  = 12'h010,
    M_ZERO   = 12'h020,
    M_NUM    = 12'h040,
    M_CQ     = 12'h080,
    M_CESC   = 12'h100,
    M_COCT   = 12'h200,
    M_CHEX   = 12'h400,
    M_CCLOSE = 12'h800
  } mode_t;

  typedef enum logic [3:0] {
    OP_BANG, OP_PCT, OP_AMP, OP_STAR, OP_PLUS, OP_MINUS, OP_EQ, OP_CARET,
    OP_BAR, OP_LT, OP_LTLT, OP_GT, OP_GTGT, OP_DOT, OP_DOTDOT, OP_SLASH
  } op_t;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_OCT = 2'd1,
    RX_HEX = 2'd2
  } radix_t;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_DIGIT    = 3'd1;
  localparam logic [2:0] ERR_ESC      = 3'd2;
  localparam logic [2:0] ERR_CHAR     = 3'd3;
  localparam logic [2:0] ERR_ODD      = 3'd4;
  localparam logic [2:0] ERR_ELLIPSIS = 3'd5;
  localparam logic [2:0] ERR_LONG     = 3'd6;

  localparam logic [6:0] TK_NOT = 7'd0, TK_NE = 7'd1, TK_MOD = 7'd2, TK_MOD_EQ = 7'd3;
  localparam logic [6:0] TK_AND = 7'd4, TK_LAND = 7'd5, TK_AND_EQ = 7'd6;
  localparam logic [6:0] TK_LPAREN = 7'd7, TK_RPAREN = 7'd8, TK_MUL = 7'd9;
  localparam logic [6:0] TK_MUL_EQ = 7'd10, TK_ADD = 7'd11, TK_INC = 7'd12;
  localparam logic [6:0] TK_ADD_EQ = 7'd13, TK_COMMA = 7'd14, TK_SUB = 7'd15;
  localparam logic [6:0] TK_DEC = 7'd16, TK_SUB_EQ = 7'd17, TK_ARROW = 7'd18;
  localparam logic [6:0] TK_DIV = 7'd19, TK_DIV_EQ = 7'd20, TK_COLON = 7'd21;
  localparam logic [6:0] TK_SEMI = 7'd22, TK_LT = 7'd23, TK_SHL = 7'd24;
  localparam logic [6:0] TK_SHL_EQ = 7'd25, TK_LE = 7'd26, TK_ASSIGN = 7'd27;
  localparam logic [6:0] TK_EQ = 7'd28, TK_GT = 7'd29, TK_SHR = 7'd30;
  localparam logic [6:0] TK_SHR_EQ = 7'd31, TK_GE = 7'd32, TK_QUEST = 7'd33;
  localparam logic [6:0] TK_LBRACK = 7'd34, TK_RBRACK = 7'd35, TK_XOR = 7'd36;
  localparam logic [6:0] TK_XOR_EQ = 7'd37, TK_LBRACE = 7'd38, TK_OR = 7'd39;
  localparam logic [6:0] TK_LOR = 7'd40, TK_OR_EQ = 7'd41, TK_RBRACE = 7'd42;
  localparam logic [6:0] TK_TILDE = 7'd43, TK_DOT = 7'd44, TK_ELLIPSIS = 7'd45;
  localparam logic [6:0] TK_KW0 = 7'd46, TK_NUM = 7'd75, TK_IDENT = 7'd76;
  localparam logic [6:0] TK_END = 7'd77, TK_ODD = 7'd78;

  localparam int KW_COUNT = 29;

  // right-justified text, first character in the highest used byte
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'("auto"), 64'("asm"), 64'("break"), 64'("case"), 64'("char"), 64'("const"),
    64'("continue"), 64'("default"), 64'("do"), 64'("else"), 64'("enum"),
    64'("extern"), 64'("for"), 64'("goto"), 64'("if"), 64'("int"), 64'("register"),
    64'("return"), 64'("signed"), 64'("sizeof"), 64'("static"), 64'("struct"),
    64'("switch"), 64'("typedef"), 64'("union"), 64'("unsigned"), 64'("void"),
    64'("volatile"), 64'("while")
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd4, 4'd3, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2, 4'd4, 4'd4, 4'd6, 4'd3,
    4'd4, 4'd2, 4'd3, 4'd8, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd7, 4'd5, 4'd8,
    4'd4, 4'd8, 4'd5
  };

  // chars holds identifier character k at bits [8k+7:8k]; returns {hit, index}
  function automatic logic [5:0] kw_lookup(input logic [63:0] chars,
                                           input logic [7:0] len);
    logic [5:0] res;
    logic       eq;
    int         pos;
    res = '0;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      eq = (len == {4'd0, KW_LEN[i]});
      for (int k = 0; k < 8; k++) begin
        pos = (int'(KW_LEN[i]) - 1 - k) & 7;
        if (k < int'(KW_LEN[i]) && chars[8*k +: 8] != KW_TEXT[i][8*pos +: 8])
          eq = 1'b0;
      end
      if (eq) res = {1'b1, 5'(i)};
    end
    return res;
  endfunction

  function automatic logic [6:0] op_alone(input op_t op);
    logic [6:0] t;
    case (op)
      OP_BANG:   t = TK_NOT;
      OP_PCT:    t = TK_MOD;
      OP_AMP:    t = TK_AND;
      OP_STAR:   t = TK_MUL;
      OP_PLUS:   t = TK_ADD;
      OP_MINUS:  t = TK_SUB;
      OP_EQ:     t = TK_ASSIGN;
      OP_CARET:  t = TK_XOR;
      OP_BAR:    t = TK_OR;
      OP_LT:     t = TK_LT;
      OP_LTLT:   t = TK_SHL;
      OP_GT:     t = TK_GT;
      OP_GTGT:   t = TK_SHR;
      OP_DOT:    t = TK_DOT;
      OP_DOTDOT: t = TK_ELLIPSIS;
      OP_SLASH:  t = TK_DIV;
      default:   t = TK_NOT;
    endcase
    return t;
  endfunction

  // {hit, token} when ch extends the operator prefix to a full token
  function automatic logic [7:0] op_ext(input op_t op, input logic [7:0] ch);
    logic [7:0] r;
    r = '0;
    case (op)
      OP_BANG:   if (ch == "=") r = {1'b1, TK_NE};
      OP_PCT:    if (ch == "=") r = {1'b1, TK_MOD_EQ};
      OP_AMP:    if (ch == "&") r = {1'b1, TK_LAND};
                 else if (ch == "=") r = {1'b1, TK_AND_EQ};
      OP_STAR:   if (ch == "=") r = {1'b1, TK_MUL_EQ};
      OP_PLUS:   if (ch == "+") r = {1'b1, TK_INC};
                 else if (ch == "=") r = {1'b1, TK_ADD_EQ};
      OP_MINUS:  if (ch == "-") r = {1'b1, TK_DEC};
                 else if (ch == "=") r = {1'b1, TK_SUB_EQ};
                 else if (ch == ">") r = {1'b1, TK_ARROW};
      OP_EQ:     if (ch == "=") r = {1'b1, TK_EQ};
      OP_CARET:  if (ch == "=") r = {1'b1, TK_XOR_EQ};
      OP_BAR:    if (ch == "|") r = {1'b1, TK_LOR};
                 else if (ch == "=") r = {1'b1, TK_OR_EQ};
      OP_LT:     if (ch == "=") r = {1'b1, TK_LE};
      OP_LTLT:   if (ch == "=") r = {1'b1, TK_SHL_EQ};
      OP_GT:     if (ch == "=") r = {1'b1, TK_GE};
      OP_GTGT:   if (ch == "=") r = {1'b1, TK_SHR_EQ};
      OP_DOTDOT: if (ch == ".") r = {1'b1, TK_ELLIPSIS};
      OP_SLASH:  if (ch == "=") r = {1'b1, TK_DIV_EQ};
      default:   r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/c_token_lexer.sv =====
// channel  dir  handshake          payload
// in_      in   in_valid/in_stall  ctlex_in_t  {ch, end_of_input}
// out_     out  out_valid/out_stall ctlex_out_t {token_kind, value, error_code, last}
//
// one character per cycle while in_stall is low: the scanner state updates on each transfer
// each character gives zero, one or two tokens, written into a four-entry result queue
// in_stall rises while the queue holds more than two tokens
// results are registered into the queue on the transfer that made them and leave on out_ oldest first
// synchronous active-low reset returns the scanner to idle and empties the queue
module c_token_lexer #(
  parameter int MAX_IDENT_LEN = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ctlex_pkg::ctlex_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output ctlex_pkg::ctlex_out_t out_data
);

  ctlex_pkg::ctlex_emit_t emit;
  logic                   full;
  logic                   fire;

  assign in_stall = full;
  assign fire     = in_valid && !full;

  ctlex_core #(
    .MAX_IDENT_LEN(MAX_IDENT_LEN)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .in_item (in_data),
    .emit    (emit)
  );

  ctlex_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (emit),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/ctlex_core.sv =====
module ctlex_core #(
  parameter int MAX_IDENT_LEN = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  ctlex_pkg::ctlex_in_t  in_item,
  output ctlex_pkg::ctlex_emit_t emit
);

  localparam logic [7:0] LEN_MAX  = 8'(MAX_IDENT_LEN);
  localparam logic [7:0] LEN_LAST = 8'(MAX_IDENT_LEN - 1);

  ctlex_pkg::mode_t  mode_r, mode_nxt;
  ctlex_pkg::op_t    op_r, op_nxt;
  ctlex_pkg::radix_t radix_r, radix_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [7:0]  ilen_r, ilen_nxt;
  logic [1:0]  esc_r, esc_nxt;
  logic        star_r, star_nxt;
  logic [2:0]  perr_r, perr_nxt;
  logic [7:0]  ident_r [8];

  logic        wr_en;
  logic [2:0]  wr_idx;
  logic [7:0]  ch;
  logic        d_hit;
  logic [3:0]  d_val;
  logic [7:0]  lc;
  logic [63:0] ident_flat;
  logic [5:0]  kw;
  logic [6:0]  ident_kind;
  logic [31:0] acc_mul;
  logic [31:0] acc_dig;
  logic [31:0] acc_hex;
  logic [7:0]  ext;
  logic        start;
  logic        e1, e2;
  ctlex_pkg::ctlex_out_t r1, r2;
  logic [2:0]  close_err;

  assign ch = in_item.ch;
  assign lc = ch | 8'h20;

  always_comb begin
    d_hit = 1'b0;
    d_val = '0;
    if (ch >= "0" && ch <= "9") begin
      d_hit = 1'b1;
      d_val = 4'(ch - "0");
    end else if (lc >= "a" && lc <= "f") begin
      d_hit = 1'b1;
      d_val = 4'(lc - "a" + 8'd10);
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) ident_flat[8*k +: 8] = ident_r[k];
  end

  assign kw         = ctlex_pkg::kw_lookup(ident_flat, ilen_r);
  assign ident_kind = kw[5] ? ctlex_pkg::TK_KW0 + {2'd0, kw[4:0]} : ctlex_pkg::TK_IDENT;

  always_comb begin
    case (radix_r)
      ctlex_pkg::RX_HEX: acc_mul = {acc_r[27:0], 4'd0};
      ctlex_pkg::RX_OCT: acc_mul = {acc_r[28:0], 3'd0};
      default:           acc_mul = {acc_r[28:0], 3'd0} + {acc_r[30:0], 1'b0};
    endcase
  end
  assign acc_dig = acc_mul + {28'd0, d_val};
  assign acc_hex = {acc_r[27:0], 4'd0} + {28'd0, d_val};
  assign ext     = ctlex_pkg::op_ext(op_r, ch);
  assign close_err = (perr_r != ctlex_pkg::ERR_NONE) ? perr_r :
                     ((ch == "'") ? ctlex_pkg::ERR_NONE : ctlex_pkg::ERR_CHAR);

  always_comb begin
    mode_nxt  = mode_r;
    op_nxt    = op_r;
    radix_nxt = radix_r;
    acc_nxt   = acc_r;
    ilen_nxt  = ilen_r;
    esc_nxt   = esc_r;
    star_nxt  = star_r;
    perr_nxt  = perr_r;
    wr_en     = 1'b0;
    wr_idx    = ilen_r[2:0];
    start     = 1'b0;
    e1        = 1'b0;
    e2        = 1'b0;
    r1        = '0;
    r2        = '0;

    if (in_item.end_of_input) begin
      // close the open token, then the end marker
      case (mode_r)
        ctlex_pkg::M_OP: begin
          e1 = 1'b1;
          r1.token_kind = ctlex_pkg::op_alone(op_r);
          r1.error_code = (op_r == ctlex_pkg::OP_DOTDOT) ? ctlex_pkg::ERR_ELLIPSIS
                                                         : ctlex_pkg::ERR_NONE;
        end
        ctlex_pkg::M_IDENT: begin
          e1 = 1'b1;
          r1.token_kind = ident_kind;
          r1.value      = {24'd0, ilen_r};
          r1.error_code = perr_r;
        end
        ctlex_pkg::M_ZERO, ctlex_pkg::M_NUM: begin
          e1 = 1'b1;
          r1.token_kind = ctlex_pkg::TK_NUM;
          r1.value      = acc_r;
          r1.error_code = perr_r;
        end
        ctlex_pkg::M_CQ, ctlex_pkg::M_CESC, ctlex_pkg::M_COCT,
        ctlex_pkg::M_CHEX, ctlex_pkg::M_CCLOSE: begin
          e1 = 1'b1;
          r1.token_kind = ctlex_pkg::TK_NUM;
          r1.value      = acc_r;
          if (perr_r != ctlex_pkg::ERR_NONE)
            r1.error_code = perr_r;
          else if (mode_r == ctlex_pkg::M_CHEX && esc_r != 2'd1)
            r1.error_code = ctlex_pkg::ERR_ESC;
          else
            r1.error_code = ctlex_pkg::ERR_CHAR;
        end
        default: e1 = 1'b0;
      endcase
      e2 = 1'b1;
      r2.token_kind = ctlex_pkg::TK_END;
      mode_nxt = ctlex_pkg::M_IDLE;
    end else begin
      case (mode_r)
        ctlex_pkg::M_IDLE: start = 1'b1;
        ctlex_pkg::M_OP: begin
          if (op_r == ctlex_pkg::OP_LT && ch == "<") op_nxt = ctlex_pkg::OP_LTLT;
          else if (op_r == ctlex_pkg::OP_GT && ch == ">") op_nxt = ctlex_pkg::OP_GTGT;
          else if (op_r == ctlex_pkg::OP_DOT && ch == ".") op_nxt = ctlex_pkg::OP_DOTDOT;
          else if (op_r == ctlex_pkg::OP_SLASH && ch == "*") begin
            mode_nxt = ctlex_pkg::M_BLOCK;
            star_nxt = 1'b0;
          end else if (op_r == ctlex_pkg::OP_SLASH && ch == "/") begin
            mode_nxt = ctlex_pkg::M_LINE;
          end else begin
            mode_nxt = ctlex_pkg::M_IDLE;
            e1 = 1'b1;
            if (ext[7]) begin
              r1.token_kind = ext[6:0];
            end else begin
              r1.token_kind = ctlex_pkg::op_alone(op_r);
              r1.error_code = (op_r == ctlex_pkg::OP_DOTDOT) ? ctlex_pkg::ERR_ELLIPSIS
                                                             : ctlex_pkg::ERR_NONE;
              start = 1'b1;
            end
          end
        end
        ctlex_pkg::M_LINE: if (ch == "\n") mode_nxt = ctlex_pkg::M_IDLE;
        ctlex_pkg::M_BLOCK: begin
          if (ch == "/" && star_r) mode_nxt = ctlex_pkg::M_IDLE;
          star_nxt = (ch == "*");
        end
        ctlex_pkg::M_IDENT: begin
          if ((lc >= "a" && lc <= "z") || (ch >= "0" && ch <= "9") || ch == "_") begin
            wr_en = (ilen_r < 8'd8);
            if (ilen_r == LEN_LAST) begin
              if (perr_r == ctlex_pkg::ERR_NONE) perr_nxt = ctlex_pkg::ERR_LONG;
              ilen_nxt = LEN_MAX;
            end else if (ilen_r < LEN_LAST) begin
              ilen_nxt = ilen_r + 8'd1;
            end
          end else begin
            e1 = 1'b1;
            r1.token_kind = ident_kind;
            r1.value      = {24'd0, ilen_r};
            r1.error_code = perr_r;
            mode_nxt = ctlex_pkg::M_IDLE;
            start = 1'b1;
          end
        end
        ctlex_pkg::M_ZERO, ctlex_pkg::M_NUM: begin
          mode_nxt = ctlex_pkg::M_NUM;
          if (mode_r == ctlex_pkg::M_ZERO && ch == "x") begin
            radix_nxt = ctlex_pkg::RX_HEX;
          end else if (d_hit) begin
            if (perr_r == ctlex_pkg::ERR_NONE &&
                ((radix_r == ctlex_pkg::RX_DEC && d_val > 4'd9) ||
                 (radix_r == ctlex_pkg::RX_OCT && d_val > 4'd7)))
              perr_nxt = ctlex_pkg::ERR_DIGIT;
            acc_nxt = acc_dig;
          end else begin
            e1 = 1'b1;
            r1.token_kind = ctlex_pkg::TK_NUM;
            r1.value      = acc_r;
            r1.error_code = perr_r;
            mode_nxt = ctlex_pkg::M_IDLE;
            start = 1'b1;
          end
        end
        ctlex_pkg::M_CQ: begin
          if (ch == "\\") begin
            mode_nxt = ctlex_pkg::M_CESC;
          end else begin
            acc_nxt  = {24'd0, ch};
            mode_nxt = ctlex_pkg::M_CCLOSE;
          end
        end
        ctlex_pkg::M_CESC: begin
          mode_nxt = ctlex_pkg::M_CCLOSE;
          case (ch)
            "a":  acc_nxt = 32'd7;
            "b":  acc_nxt = 32'd8;
            "e":  acc_nxt = 32'd27;
            "f":  acc_nxt = 32'd12;
            "n":  acc_nxt = 32'd10;
            "r":  acc_nxt = 32'd13;
            "t":  acc_nxt = 32'd9;
            "v":  acc_nxt = 32'd11;
            "\\": acc_nxt = 32'd92;
            "'":  acc_nxt = 32'd39;
            "\"": acc_nxt = 32'd34;
            "\n": acc_nxt = 32'd32;
            "x": begin
              acc_nxt  = '0;
              esc_nxt  = 2'd0;
              mode_nxt = ctlex_pkg::M_CHEX;
            end
            default: begin
              if (ch >= "0" && ch <= "7") begin
                acc_nxt  = {28'd0, d_val};
                esc_nxt  = 2'd1;
                mode_nxt = ctlex_pkg::M_COCT;
              end else begin
                acc_nxt = 32'd32;
                if (perr_r == ctlex_pkg::ERR_NONE) perr_nxt = ctlex_pkg::ERR_ESC;
              end
            end
          endcase
        end
        ctlex_pkg::M_COCT: begin
          if (ch >= "0" && ch <= "7" && esc_r < 2'd3) begin
            acc_nxt = {acc_r[28:0], 3'd0} + {28'd0, d_val};
            esc_nxt = esc_r + 2'd1;
          end else begin
            // the ending character is the closing quote slot
            e1 = 1'b1;
            r1.token_kind = ctlex_pkg::TK_NUM;
            r1.value      = acc_r;
            r1.error_code = close_err;
            mode_nxt = ctlex_pkg::M_IDLE;
          end
        end
        ctlex_pkg::M_CHEX: begin
          if (d_hit) begin
            acc_nxt = acc_hex;
            if (esc_r == 2'd0) esc_nxt = 2'd1;
            if (acc_hex > 32'd255) esc_nxt = 2'd3;
          end else begin
            e1 = 1'b1;
            r1.token_kind = ctlex_pkg::TK_NUM;
            r1.value      = acc_r;
            if (perr_r == ctlex_pkg::ERR_NONE && esc_r != 2'd1)
              r1.error_code = ctlex_pkg::ERR_ESC;
            else
              r1.error_code = close_err;
            mode_nxt = ctlex_pkg::M_IDLE;
          end
        end
        ctlex_pkg::M_CCLOSE: begin
          e1 = 1'b1;
          r1.token_kind = ctlex_pkg::TK_NUM;
          r1.value      = acc_r;
          r1.error_code = close_err;
          mode_nxt = ctlex_pkg::M_IDLE;
        end
        default: mode_nxt = ctlex_pkg::M_IDLE;
      endcase

      // character taken in idle, or seen again from idle after it ended a token
      if (start) begin
        case (ch)
          " ", "\t", "\n", "\r", 8'h0c: mode_nxt = ctlex_pkg::M_IDLE;
          "!": begin mode_nxt = ctlex_pkg::M_OP; op_nxt = ctlex_pkg::OP_BANG;  end
          "%": begin mode_nxt = ctlex_pkg::M_OP; op_nxt = ctlex_pkg::OP_PCT;   end
          "&": begin mode_nxt = ctlex_pkg::M_OP; op_nxt = ctlex_pkg::OP_AMP;   end
          "*": begin mode_nxt = ctlex_pkg::M_OP; op_nxt = ctlex_pkg::OP_STAR;  end
          "+": begin mode_nxt = ctlex_pkg::M_OP; op_nxt = ctlex_pkg::OP_PLUS;  end
          "-": begin mode_nxt = ctlex_pkg::M_OP; op_nxt = ctlex_pkg::OP_MINUS; end
          "=": begin mode_nxt = ctlex_pkg::M_OP; op_nxt = ctlex_pkg::OP_EQ;    end
          "^": begin mode_nxt = ctlex_pkg::M_OP; op_nxt = ctlex_pkg::OP_CARET; end
          "|": begin mode_nxt = ctlex_pkg::M_OP; op_nxt = ctlex_pkg::OP_BAR;   end
          "<": begin mode_nxt = ctlex_pkg::M_OP; op_nxt = ctlex_pkg::OP_LT;    end
          ">": begin mode_nxt = ctlex_pkg::M_OP; op_nxt = ctlex_pkg::OP_GT;    end
          ".": begin mode_nxt = ctlex_pkg::M_OP; op_nxt = ctlex_pkg::OP_DOT;   end
          "/": begin mode_nxt = ctlex_pkg::M_OP; op_nxt = ctlex_pkg::OP_SLASH; end
          "(": begin e2 = 1'b1; r2.token_kind = ctlex_pkg::TK_LPAREN; end
          ")": begin e2 = 1'b1; r2.token_kind = ctlex_pkg::TK_RPAREN; end
          ",": begin e2 = 1'b1; r2.token_kind = ctlex_pkg::TK_COMMA;  end
          ":": begin e2 = 1'b1; r2.token_kind = ctlex_pkg::TK_COLON;  end
          ";": begin e2 = 1'b1; r2.token_kind = ctlex_pkg::TK_SEMI;   end
          "?": begin e2 = 1'b1; r2.token_kind = ctlex_pkg::TK_QUEST;  end
          "[": begin e2 = 1'b1; r2.token_kind = ctlex_pkg::TK_LBRACK; end
          "]": begin e2 = 1'b1; r2.token_kind = ctlex_pkg::TK_RBRACK; end
          "{": begin e2 = 1'b1; r2.token_kind = ctlex_pkg::TK_LBRACE; end
          "}": begin e2 = 1'b1; r2.token_kind = ctlex_pkg::TK_RBRACE; end
          "~": begin e2 = 1'b1; r2.token_kind = ctlex_pkg::TK_TILDE;  end
          "'": begin
            acc_nxt  = '0;
            perr_nxt = ctlex_pkg::ERR_NONE;
            mode_nxt = ctlex_pkg::M_CQ;
          end
          "0": begin
            acc_nxt   = '0;
            radix_nxt = ctlex_pkg::RX_OCT;
            perr_nxt  = ctlex_pkg::ERR_NONE;
            mode_nxt  = ctlex_pkg::M_ZERO;
          end
          default: begin
            if (ch >= "1" && ch <= "9") begin
              acc_nxt   = {28'd0, d_val};
              radix_nxt = ctlex_pkg::RX_DEC;
              perr_nxt  = ctlex_pkg::ERR_NONE;
              mode_nxt  = ctlex_pkg::M_NUM;
            end else if ((lc >= "a" && lc <= "z") || ch == "_") begin
              wr_en    = 1'b1;
              wr_idx   = 3'd0;
              ilen_nxt = 8'd1;
              perr_nxt = ctlex_pkg::ERR_NONE;
              mode_nxt = ctlex_pkg::M_IDENT;
            end else begin
              e2 = 1'b1;
              r2.token_kind = ctlex_pkg::TK_ODD;
              r2.value      = {24'd0, ch};
              r2.error_code = ctlex_pkg::ERR_ODD;
            end
          end
        endcase
      end
    end
  end

  always_comb begin
    emit = '0;
    if (fire) begin
      if (e1 && e2) begin
        emit.cnt  = 2'd2;
        emit.res0 = r1;
        emit.res1 = r2;
        emit.res1.last = 1'b1;
      end else if (e1 || e2) begin
        emit.cnt  = 2'd1;
        emit.res0 = e1 ? r1 : r2;
        emit.res0.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ctlex_pkg::M_IDLE;
      op_r    <= ctlex_pkg::OP_BANG;
      radix_r <= ctlex_pkg::RX_DEC;
      acc_r   <= '0;
      ilen_r  <= '0;
      esc_r   <= '0;
      star_r  <= 1'b0;
      perr_r  <= ctlex_pkg::ERR_NONE;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      op_r    <= op_nxt;
      radix_r <= radix_nxt;
      acc_r   <= acc_nxt;
      ilen_r  <= ilen_nxt;
      esc_r   <= esc_nxt;
      star_r  <= star_nxt;
      perr_r  <= perr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && wr_en) ident_r[wr_idx] <= ch;
  end

`ifndef SYNTHESIS
  a_mode_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(mode_r)) else $error("lexer mode not one-hot");
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_item.end_of_input |=> mode_r == ctlex_pkg::M_IDLE)
    else $error("lexer not idle after end of input");
  a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_item.end_of_input |-> emit.cnt != 2'd0)
    else $error("end of input gave no token");
  a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ilen_r <= LEN_MAX) else $error("identifier length past cap");
`endif

endmodule

// ===== hw/rtl/ctlex_fifo.sv =====
module ctlex_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ctlex_pkg::ctlex_emit_t emit,
  output logic                   full,
  output logic                   out_valid,
  input  logic                   out_stall,
  output ctlex_pkg::ctlex_out_t  out_data
);

  ctlex_pkg::ctlex_out_t q_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] cnt_r;
  logic       pop;

  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = q_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  // room for two results is needed before the next transfer in
  assign full      = (cnt_r > 3'd2);

  always_ff @(posedge clk) begin
    if (emit.cnt != 2'd0) q_r[wr_ptr_r] <= emit.res0;
    if (emit.cnt == 2'd2) q_r[wr_ptr_r + 2'd1] <= emit.res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + emit.cnt;
      if (pop) rd_ptr_r <= rd_ptr_r + 2'd1;
      cnt_r <= cnt_r + {1'b0, emit.cnt} - {2'd0, pop};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4) else $error("result queue overflow");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit.cnt != 2'd0 |-> !full) else $error("push into full result queue");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 3'd0 || cnt_r == 3'd4) |-> wr_ptr_r == rd_ptr_r)
    else $error("result queue pointers out of step");
`endif

endmodule
